[hdl/buffer_energy_power_estimator_defines.svh]
// -----------------------------------------------------------------------------
// Buffer energy power estimator: assertion macros
// Shared property forms for the checker of the estimator ports.
// -----------------------------------------------------------------------------
`ifndef BUFFER_ENERGY_POWER_ESTIMATOR_DEFINES_SVH
`define BUFFER_ENERGY_POWER_ESTIMATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEPE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BEPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bepe_pkg.sv]
// -----------------------------------------------------------------------------
// Buffer energy power estimator package
// Field widths, the default window and the shared median/trend bundle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bepe_pkg;

	localparam int SAMPLE_W       = 12;
	localparam int CAP_W          = 10;
	localparam int EST_W          = 20;
	localparam int WINDOW_DEFAULT = 5;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CAP_W-1:0]    cap_t;
	typedef logic [EST_W-1:0]    est_t;

	typedef struct packed {
		sample_t median;
		sample_t newest;
		sample_t oldest;
	} bepe_calc_t;

endpackage

`default_nettype wire

[hdl/bepe_sample_if.sv]
// -----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one energy sample and the power cap.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bepe_sample_if import bepe_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t energy_sample;
	cap_t    power_cap;

	modport source (output valid, output energy_sample, output power_cap, input ready);
	modport sink   (input valid, input energy_sample, input power_cap, output ready);
endinterface

`default_nettype wire

[hdl/bepe_estimate_if.sv]
// -----------------------------------------------------------------------------
// Estimate channel
// Valid/ready channel that carries one smoothed power estimate.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bepe_estimate_if import bepe_pkg::*;;
	logic valid;
	logic ready;
	est_t power_estimate;

	modport source (output valid, output power_estimate, input ready);
	modport sink   (input valid, input power_estimate, output ready);
endinterface

`default_nettype wire

[hdl/bepe_median.sv]
// -----------------------------------------------------------------------------
// Window median
// Ranks every ring entry against all others and picks the middle rank.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bepe_median import bepe_pkg::*; #(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  sample_t ring [WINDOW],
	output sample_t median
);

	localparam int RANK_W = $clog2(WINDOW);

	logic [RANK_W-1:0] rank [WINDOW];

	// Ties are broken by position, so the ranks form a permutation.
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if ((ring[j] < ring[i]) || ((ring[j] == ring[i]) && (j < i))) begin
					rank[i] = rank[i] + RANK_W'(1);
				end
			end
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (rank[i] == RANK_W'(WINDOW / 2)) begin
				median = median | ring[i];
			end
		end
	end

endmodule

`default_nettype wire

[hdl/bepe_update.sv]
// -----------------------------------------------------------------------------
// Estimate update
// Picks the raw power from median and trend, smooths it and clamps it.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bepe_update import bepe_pkg::*; (
	input  bepe_calc_t calc,
	input  cap_t       power_cap,
	input  est_t       est_prev,
	output est_t       est_next
);

	localparam int TREND_W = SAMPLE_W + 1;
	localparam int RAW_W   = 16;
	localparam int SUM_W   = 25;
	localparam int QUOT_W  = SUM_W - 3;

	logic signed [TREND_W-1:0] trend;
	logic        [SAMPLE_W-1:0] trend_mag;
	logic        [SAMPLE_W+2:0] five_mag;
	logic signed [RAW_W-1:0]    raw;
	logic        [EST_W+1:0]    est_triple;
	logic signed [SUM_W-1:0]    sum;
	logic        [QUOT_W-1:0]   quot;
	est_t                       upper;

	always_comb begin
		trend     = $signed({1'b0, calc.newest}) - $signed({1'b0, calc.oldest});
		trend_mag = trend[TREND_W-1] ? SAMPLE_W'(-trend) : SAMPLE_W'(trend);
		five_mag  = (SAMPLE_W + 3)'({trend_mag, 2'b00}) + (SAMPLE_W + 3)'(trend_mag);

		if (calc.median == '0) begin
			raw = $signed(RAW_W'(power_cap));
		end else if (trend[TREND_W-1]) begin
			raw = $signed(RAW_W'(power_cap) + RAW_W'(five_mag));
		end else if (trend != '0) begin
			raw = $signed(RAW_W'(power_cap) - RAW_W'(2));
		end else begin
			raw = $signed(RAW_W'(power_cap) + RAW_W'(2));
		end

		est_triple = (EST_W + 2)'({est_prev, 1'b0}) + (EST_W + 2)'(est_prev);
		sum        = (SUM_W'(raw) <<< 8) + $signed(SUM_W'(est_triple));
		quot       = sum[SUM_W-1] ? '0 : sum[SUM_W-2:2];
		upper      = EST_W'({power_cap, 9'b0}) + EST_W'({power_cap, 7'b0});

		if (quot > QUOT_W'(upper)) begin
			est_next = upper;
		end else begin
			est_next = quot[EST_W-1:0];
		end
	end

endmodule

`default_nettype wire

[hdl/buffer_energy_power_estimator.sv]
// -----------------------------------------------------------------------------
// Buffer energy power estimator
// Sliding median of energy samples, a short trend and a smoothed power
// estimate clamped to two and a half times the power cap.
// -----------------------------------------------------------------------------
//
//  Channel    Dir  Payload                               Beat
//  sample     in   energy_sample[11:0], power_cap[9:0]   one request per step
//  estimate   out  power_estimate[19:0] (Q.8 watts)      one per sample
//
// An accepted request is registered, then ring update, median, trend and
// smoothing run combinationally into the result register, fed back as est_q.
// A new request can be taken every cycle while the estimate is not stalled.
// Reset clears the ring, write slot, estimate and both valid flags.
// A stalled estimate holds the input register, and the sample side then stalls.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buffer_energy_power_estimator import bepe_pkg::*; #(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bepe_sample_if.sink            sample,
	bepe_estimate_if.source        estimate
);

	localparam int SLOT_W = $clog2(WINDOW);

	logic              valid_s1;
	sample_t           sample_s1;
	cap_t              cap_s1;
	logic              out_valid_q;
	est_t              est_q;
	sample_t           ring_q    [WINDOW];
	sample_t           ring_next [WINDOW];
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] old_slot;
	logic              advance;
	sample_t           ring_median;
	bepe_calc_t        calc;
	est_t              est_next;

	assign advance      = valid_s1 && (!out_valid_q || estimate.ready);
	assign sample.ready = !valid_s1 || advance;

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			ring_next[i] = (slot_q == SLOT_W'(i)) ? sample_s1 : ring_q[i];
		end
		old_slot = (slot_q >= SLOT_W'(2)) ? (slot_q - SLOT_W'(2))
		                                  : (slot_q + SLOT_W'(WINDOW - 2));
		calc.median = ring_median;
		calc.newest = sample_s1;
		calc.oldest = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (old_slot == SLOT_W'(i)) begin
				calc.oldest = ring_q[i];
			end
		end
	end

	bepe_median #(
		.WINDOW (WINDOW)
	) u_median (
		.ring   (ring_next),
		.median (ring_median)
	);

	bepe_update u_update (
		.calc      (calc),
		.power_cap (cap_s1),
		.est_prev  (est_q),
		.est_next  (est_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample.energy_sample;
			cap_s1    <= sample.power_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			est_q       <= '0;
			slot_q      <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i] <= '0;
			end
		end else if (advance) begin
			out_valid_q <= 1'b1;
			est_q       <= est_next;
			slot_q      <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : (slot_q + SLOT_W'(1));
			ring_q      <= ring_next;
		end else if (estimate.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign estimate.valid          = out_valid_q;
	assign estimate.power_estimate = est_q;

endmodule

`default_nettype wire

[hdl/bepe_checker.sv]
// -----------------------------------------------------------------------------
// Buffer energy power estimator checker
// Port-level properties of the estimator, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "buffer_energy_power_estimator_defines.svh"

module bepe_checker import bepe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input est_t power_estimate
);

	`BEPE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(power_estimate), "stalled estimate changed")
	`BEPE_ASSERT_SAME(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "sample side stalled without a blocked estimate")
	`BEPE_ASSERT_SAME(a_first_result, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "estimate appeared without a request two cycles before")
	`BEPE_ASSERT_SAME(a_range, clk, arst_n, out_valid, power_estimate <= 20'd654720, "estimate above the clamp range")

endmodule

bind buffer_energy_power_estimator bepe_checker u_bepe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sample.valid),
	.in_ready       (sample.ready),
	.out_valid      (estimate.valid),
	.out_ready      (estimate.ready),
	.power_estimate (estimate.power_estimate)
);

`default_nettype wire

[tb/sv/buffer_energy_power_estimator_tb.sv]
// -----------------------------------------------------------------------------
// Buffer energy power estimator testbench
// Sends energy-sample requests through the sample channel and checks every
// smoothed power estimate against a cycle-free model of the median, trend and
// smoothing path. A directed opening is followed by random sample sequences
// in several phases of sender and receiver idling.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buffer_energy_power_estimator_tb;
	import bepe_pkg::*;

	localparam int RING_DEPTH  = WINDOW_DEFAULT;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 460;

	typedef struct packed {
		sample_t energy;
		cap_t    cap;
	} request_t;

	typedef enum int {
		SEQ_NOISE,
		SEQ_WALK,
		SEQ_HOLD,
		SEQ_SPARSE,
		SEQ_TOGGLE,
		SEQ_RAMP
	} seq_kind_t;

	logic clk;
	logic arst_n;

	bepe_sample_if   sample_ch ();
	bepe_estimate_if estimate_ch ();

	buffer_energy_power_estimator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.estimate (estimate_ch)
	);

	request_t pending_requests[$];
	est_t     pending_estimates[$];

	sample_t  energy_ring[RING_DEPTH];
	int       ring_slot;
	est_t     smoothed_estimate;

	int       send_idle_pct;
	int       stall_pct;
	logic     req_taken;
	int       idle_cycles;
	int       fail_count;

	always #5 clk = ~clk;

	// Model of one step: ring write, median, trend, raw power, smoothing and clamp.
	function automatic est_t estimate_power(sample_t energy, cap_t cap);
		sample_t sorted[RING_DEPTH];
		sample_t hold;
		sample_t median;
		int      now_slot;
		int      old_slot;
		int      trend;
		int      raw;
		int      acc;
		int      upper;
		int      j;
		now_slot = ring_slot;
		energy_ring[now_slot] = energy;
		ring_slot = (now_slot + 1) % RING_DEPTH;
		sorted = energy_ring;
		for (int i = 1; i < RING_DEPTH; i++) begin
			hold = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > hold) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = hold;
		end
		median = sorted[RING_DEPTH / 2];
		old_slot = (now_slot + RING_DEPTH - 2) % RING_DEPTH;
		trend = int'(energy_ring[now_slot]) - int'(energy_ring[old_slot]);
		if (median == 0) begin
			raw = int'(cap);
		end else if (trend < 0) begin
			raw = int'(cap) - 5 * trend;
		end else if (trend > 0) begin
			raw = int'(cap) - 2;
		end else begin
			raw = int'(cap) + 2;
		end
		acc = raw * 256 + 3 * int'(smoothed_estimate);
		if (acc < 0) begin
			acc = 0;
		end else begin
			acc = acc / 4;
		end
		upper = int'(cap) * 640;
		if (acc > upper) begin
			acc = upper;
		end
		smoothed_estimate = est_t'(acc);
		return smoothed_estimate;
	endfunction

	task automatic add_request(sample_t energy, cap_t cap);
		request_t r;
		r.energy = energy;
		r.cap = cap;
		pending_requests.push_back(r);
	endtask

	task automatic queue_random_requests(int count);
		int        left;
		int        run;
		int        level;
		seq_kind_t kind;
		cap_t      cap;
		sample_t   energy;
		left = count;
		while (left > 0) begin
			run = $urandom_range(3, 12);
			kind = seq_kind_t'($urandom_range(0, 5));
			level = $urandom_range(0, 4095);
			case ($urandom_range(0, 4))
				0: cap = cap_t'(0);
				1: cap = cap_t'(1);
				2: cap = cap_t'(1023);
				3: cap = cap_t'($urandom_range(2, 40));
				default: cap = cap_t'($urandom_range(0, 1023));
			endcase
			for (int i = 0; i < run && left > 0; i++) begin
				case (kind)
					SEQ_NOISE: level = $urandom_range(0, 4095);
					SEQ_WALK: level = level + int'($urandom_range(0, 60)) - 30;
					SEQ_HOLD: ;
					SEQ_SPARSE: level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0;
					SEQ_TOGGLE: level = (i % 2 == 0) ? 4095 : 0;
					default: level = level + int'($urandom_range(0, 200));
				endcase
				if (level < 0) begin
					level = 0;
				end else if (level > 4095) begin
					level = 4095;
				end
				energy = sample_t'(level);
				add_request(energy, cap);
				if ($urandom_range(0, 7) == 0) begin
					cap = cap_t'($urandom_range(0, 1023));
				end
				left--;
			end
		end
	endtask

	// The phase ends only when every request is sent and every estimate has come back.
	task automatic play_phase(int send_pct, int recv_pct, int count);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		queue_random_requests(count);
		while (pending_requests.size() != 0 || sample_ch.valid
				|| pending_estimates.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_ch.valid || req_taken) begin
				if (pending_requests.size() != 0
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					request_t r;
					r = pending_requests.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.energy_sample <= r.energy;
					sample_ch.power_cap <= r.cap;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
			estimate_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= sample_ch.valid && sample_ch.ready;
			if (estimate_ch.valid && estimate_ch.ready) begin
				if (pending_estimates.size() == 0) begin
					$error("power_estimate: expected none, actual %0d",
						estimate_ch.power_estimate);
					fail_count++;
				end else begin
					est_t want;
					want = pending_estimates.pop_front();
					if (estimate_ch.power_estimate !== want) begin
						$error("power_estimate: expected %0d, actual %0d",
							want, estimate_ch.power_estimate);
						fail_count++;
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				pending_estimates.push_back(
					estimate_power(sample_ch.energy_sample, sample_ch.power_cap));
			end
			if ((sample_ch.valid && sample_ch.ready)
					|| (estimate_ch.valid && estimate_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.energy_sample = '0;
		sample_ch.power_cap = '0;
		estimate_ch.ready = 1'b0;
		req_taken = 1'b0;
		idle_cycles = 0;
		fail_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		ring_slot = 0;
		smoothed_estimate = '0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			energy_ring[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A zero median passes the cap through; the first full samples climb
		// toward the largest cap, and a sharp fall saturates at the upper clamp.
		add_request(12'd0, 10'd0);
		add_request(12'd4095, 10'd1023);
		add_request(12'd4095, 10'd1023);
		add_request(12'd4095, 10'd1023);
		add_request(12'd2000, 10'd1023);
		add_request(12'd0, 10'd1);
		add_request(12'd100, 10'd0);
		// Rising samples with a cap of zero or one drive the sum below zero.
		add_request(12'd4095, 10'd0);
		add_request(12'd4095, 10'd1);
		add_request(12'd1, 10'd1023);
		add_request(12'd4095, 10'd1023);
		add_request(12'd0, 10'd1023);
		add_request(12'd4095, 10'd1023);
		add_request(12'd0, 10'd1023);
		for (int i = 0; i < 5; i++) begin
			add_request(12'd2000, 10'd512);
		end
		add_request(12'hAAA, 10'h155);
		add_request(12'h555, 10'h2AA);
		add_request(12'd0, 10'd0);
		add_request(12'd4095, 10'd1023);

		play_phase(0, 0, PHASE_ITEMS);
		play_phase(64, 0, PHASE_ITEMS);
		play_phase(0, 64, PHASE_ITEMS);
		play_phase(15, 15, PHASE_ITEMS);
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (8) @(negedge clk);

		if (pending_estimates.size() != 0) begin
			$error("power_estimate: %0d expected results never arrived",
				pending_estimates.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/bepe_pkg.sv
hdl/bepe_sample_if.sv
hdl/bepe_estimate_if.sv
hdl/bepe_median.sv
hdl/bepe_update.sv
hdl/buffer_energy_power_estimator.sv
hdl/bepe_checker.sv
tb/sv/buffer_energy_power_estimator_tb.sv
